[design/cbor_pkg.sv]
// ----------------------------------------------------------------------------
// CBOR token decoder package
// Token kinds, error codes, parser phases and float widening functions.
// ----------------------------------------------------------------------------
package cbor_pkg;

	typedef enum logic [3:0] {
		TK_UINT    = 4'd0,
		TK_NEGINT  = 4'd1,
		TK_STRHEAD = 4'd2,
		TK_STRBYTE = 4'd3,
		TK_ARRAY   = 4'd4,
		TK_MAP     = 4'd5,
		TK_FALSE   = 4'd6,
		TK_TRUE    = 4'd7,
		TK_NULL    = 4'd8,
		TK_FLOAT   = 4'd9,
		TK_BREAK   = 4'd10,
		TK_ERROR   = 4'd11,
		TK_HALF    = 4'd12,
		TK_SINGLE  = 4'd13,
		TK_NONE    = 4'd15
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_UNKNOWN  = 2'd1,
		ERR_TRUNC    = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_ARG     = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_DROP    = 4'b1000
	} phase_t;

	localparam logic [7:0] B_FALSE  = 8'hf4;
	localparam logic [7:0] B_TRUE   = 8'hf5;
	localparam logic [7:0] B_NULL   = 8'hf6;
	localparam logic [7:0] B_HALF   = 8'hf9;
	localparam logic [7:0] B_SINGLE = 8'hfa;
	localparam logic [7:0] B_DOUBLE = 8'hfb;
	localparam logic [7:0] B_BREAK  = 8'hff;
	localparam logic [4:0] AI_IMM_MAX = 5'h17;
	localparam logic [4:0] AI_INDEF   = 5'h1f;

	// Half precision bits to double bits, exact.
	function automatic logic [63:0] half_to_double(input logic [15:0] h);
		logic       s;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] p;
		logic [9:0] mm;
		logic [63:0] r;
		s = h[15];
		e = h[14:10];
		m = h[9:0];
		p = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) p = 4'(i);
		end
		mm = m ^ (10'd1 << p);
		if (e == 5'd0) begin
			if (m == 10'd0) r = {s, 63'd0};
			else r = {s, 11'(p) + 11'd999, 52'({mm, 52'd0} >> p)};
		end else if (e == 5'h1f) begin
			r = (m == 10'd0) ? {s, 63'h7FF0000000000000} : {s, 63'h7FF8000000000000};
		end else begin
			r = {s, 11'(e) + 11'd1008, m, 42'd0};
		end
		return r;
	endfunction

	// Single precision bits to double bits, NaN gets the quiet bit.
	function automatic logic [63:0] single_to_double(input logic [31:0] f);
		logic        s;
		logic [7:0]  e;
		logic [22:0] m;
		logic [4:0]  p;
		logic [22:0] mm;
		logic [63:0] r;
		s = f[31];
		e = f[30:23];
		m = f[22:0];
		p = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (m[i]) p = 5'(i);
		end
		mm = m ^ (23'd1 << p);
		if (e == 8'd0) begin
			if (m == 23'd0) r = {s, 63'd0};
			else r = {s, 11'(p) + 11'd874, 52'({mm, 52'd0} >> p)};
		end else if (e == 8'hff) begin
			if (m == 23'd0) r = {s, 63'h7FF0000000000000};
			else r = {s, 11'h7ff, 1'b1, m[21:0], 29'd0};
		end else begin
			r = {s, 11'(e) + 11'd896, m, 29'd0};
		end
		return r;
	endfunction

endpackage

[design/cbor_token_decoder.sv]
// ----------------------------------------------------------------------------
// CBOR token decoder
// Byte-serial CBOR parser that emits one flat token per completed item part.
// ----------------------------------------------------------------------------
// A token appears in the output register in the cycle after the byte that
// completes it is accepted. Throughput: one byte per cycle while the input
// is not stalled; the input stalls only while a
// token waits in the output register under output stall. Reset (arst_n low)
// returns the parser to idle and empties the output register.
module cbor_token_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [63:0] token_value,
	output logic        indefinite,
	output logic        string_last,
	output logic [1:0]  error_code
);

	cbor_pkg::phase_t phase_q, phase_d;
	logic [3:0]  pkind_q, pkind_d;
	logic [3:0]  left_q, left_d;
	logic [63:0] acc_q, acc_d;
	logic [63:0] pay_q, pay_d;

	logic        emit;
	logic [3:0]  k;
	logic [63:0] v;
	logic        ind, last;
	logic [1:0]  err;

	// output register: accept when empty or being drained this cycle
	logic take;
	assign in_stall = out_valid && out_stall;
	assign take = in_valid && !in_stall;

	logic [2:0]  major;
	logic [4:0]  ai;
	logic [3:0]  mkind;
	logic [63:0] acc_next;
	logic [3:0]  fkind;
	logic [63:0] fval;

	// completion of a head: kind and value selection shared by idle and arg
	always_comb begin
		acc_next = {acc_q[55:0], data_byte};
		fkind = pkind_q;
		fval = acc_next;
		if (phase_q == cbor_pkg::PH_IDLE) begin
			fkind = mkind;
			fval = 64'(ai);
		end
	end

	always_comb begin
		major = data_byte[7:5];
		ai = data_byte[4:0];
		unique case (major)
			3'd0: mkind = cbor_pkg::TK_UINT;
			3'd1: mkind = cbor_pkg::TK_NEGINT;
			3'd3: mkind = cbor_pkg::TK_STRHEAD;
			3'd4: mkind = cbor_pkg::TK_ARRAY;
			3'd5: mkind = cbor_pkg::TK_MAP;
			default: mkind = cbor_pkg::TK_NONE;
		endcase
	end

	always_comb begin
		logic fin;
		fin = 1'b0;
		phase_d = phase_q;
		pkind_d = pkind_q;
		left_d = left_q;
		acc_d = acc_q;
		pay_d = pay_q;
		emit = 1'b0;
		k = cbor_pkg::TK_ERROR;
		v = 64'd0;
		ind = 1'b0;
		last = 1'b0;
		err = cbor_pkg::ERR_NONE;
		unique case (phase_q)
			cbor_pkg::PH_IDLE: begin
				priority if (data_byte == cbor_pkg::B_FALSE) begin
					emit = 1'b1; k = cbor_pkg::TK_FALSE;
				end else if (data_byte == cbor_pkg::B_TRUE) begin
					emit = 1'b1; k = cbor_pkg::TK_TRUE;
				end else if (data_byte == cbor_pkg::B_NULL) begin
					emit = 1'b1; k = cbor_pkg::TK_NULL;
				end else if (data_byte == cbor_pkg::B_BREAK) begin
					emit = 1'b1; k = cbor_pkg::TK_BREAK;
				end else if (data_byte == cbor_pkg::B_HALF) begin
					phase_d = cbor_pkg::PH_ARG; pkind_d = cbor_pkg::TK_HALF;
					left_d = 4'd2; acc_d = 64'd0;
				end else if (data_byte == cbor_pkg::B_SINGLE) begin
					phase_d = cbor_pkg::PH_ARG; pkind_d = cbor_pkg::TK_SINGLE;
					left_d = 4'd4; acc_d = 64'd0;
				end else if (data_byte == cbor_pkg::B_DOUBLE) begin
					phase_d = cbor_pkg::PH_ARG; pkind_d = cbor_pkg::TK_FLOAT;
					left_d = 4'd8; acc_d = 64'd0;
				end else if (mkind != cbor_pkg::TK_NONE && ai <= cbor_pkg::AI_IMM_MAX) begin
					fin = 1'b1;
				end else if (mkind != cbor_pkg::TK_NONE && ai <= 5'h1b) begin
					phase_d = cbor_pkg::PH_ARG; pkind_d = mkind;
					left_d = 4'd1 << ai[1:0]; acc_d = 64'd0;
				end else if (mkind != cbor_pkg::TK_NONE && ai == cbor_pkg::AI_INDEF
						&& mkind >= cbor_pkg::TK_STRHEAD) begin
					emit = 1'b1; k = mkind; ind = 1'b1;
				end else begin
					emit = 1'b1; k = cbor_pkg::TK_ERROR; err = cbor_pkg::ERR_UNKNOWN;
					phase_d = cbor_pkg::PH_DROP;
				end
			end
			cbor_pkg::PH_ARG: begin
				acc_d = acc_next;
				if (left_q > 4'd0) left_d = left_q - 4'd1;
				if (left_q <= 4'd1) fin = 1'b1;
			end
			cbor_pkg::PH_PAYLOAD: begin
				if (pay_q > 64'd0) pay_d = pay_q - 64'd1;
				emit = 1'b1; k = cbor_pkg::TK_STRBYTE; v = 64'(data_byte);
				last = (pay_q <= 64'd1);
				if (pay_q <= 64'd1) phase_d = cbor_pkg::PH_IDLE;
			end
			cbor_pkg::PH_DROP: ;
			default: phase_d = cbor_pkg::PH_IDLE;
		endcase
		if (fin) begin
			emit = 1'b1;
			phase_d = cbor_pkg::PH_IDLE;
			unique case (fkind)
				cbor_pkg::TK_UINT: begin k = cbor_pkg::TK_UINT; v = fval; end
				cbor_pkg::TK_NEGINT: begin k = cbor_pkg::TK_NEGINT; v = ~fval; end
				cbor_pkg::TK_STRHEAD: begin
					k = cbor_pkg::TK_STRHEAD; v = fval;
					if (fval != 64'd0) begin
						phase_d = cbor_pkg::PH_PAYLOAD; pay_d = fval;
					end
				end
				cbor_pkg::TK_ARRAY: begin k = cbor_pkg::TK_ARRAY; v = fval; end
				cbor_pkg::TK_MAP: begin k = cbor_pkg::TK_MAP; v = fval; end
				cbor_pkg::TK_HALF: begin
					k = cbor_pkg::TK_FLOAT; v = cbor_pkg::half_to_double(fval[15:0]);
				end
				cbor_pkg::TK_SINGLE: begin
					k = cbor_pkg::TK_FLOAT; v = cbor_pkg::single_to_double(fval[31:0]);
				end
				default: begin k = cbor_pkg::TK_FLOAT; v = fval; end
			endcase
		end
		if (end_of_frame) begin
			if (phase_d == cbor_pkg::PH_ARG || phase_d == cbor_pkg::PH_PAYLOAD) begin
				emit = 1'b1; k = cbor_pkg::TK_ERROR; v = 64'd0; ind = 1'b0;
				last = 1'b0; err = cbor_pkg::ERR_TRUNC;
			end
			phase_d = cbor_pkg::PH_IDLE;
			pkind_d = 4'd0;
			left_d = 4'd0;
			acc_d = 64'd0;
			pay_d = 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cbor_pkg::PH_IDLE;
			pkind_q <= 4'd0;
			left_q <= 4'd0;
			acc_q <= 64'd0;
			pay_q <= 64'd0;
		end else if (take) begin
			phase_q <= phase_d;
			pkind_q <= pkind_d;
			left_q <= left_d;
			acc_q <= acc_d;
			pay_q <= pay_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!in_stall) begin
			out_valid <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			token_kind <= k;
			token_value <= v;
			indefinite <= ind;
			string_last <= last;
			error_code <= err;
		end
	end

	// a token waiting under stall holds its place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_value))
		else $error("token lost under stall");

	// error tokens always carry a code, other tokens never do
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((token_kind == cbor_pkg::TK_ERROR) == (error_code != cbor_pkg::ERR_NONE)))
		else $error("error code mismatch");

	// end of frame always leaves the parser idle
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_frame |=> phase_q == cbor_pkg::PH_IDLE)
		else $error("parser not idle after frame end");

endmodule
